[hw/rtl/pps_pkg.sv]
// Package: widths, constants and sequencer states of the PWM prescale selector.
package pps_pkg;

  // Frequencies and the divided period
  localparam int GOAL_W = 32;

  // Counter period at scale 0 (range 2 .. 2^31)
  localparam longint unsigned NATURAL_PERIOD = 64'd65536;

  // Prescale exponent
  localparam int SCALE_W = 4;
  localparam logic [SCALE_W-1:0] SCALE_TOP = 4'hF;

  // Candidate period: natural period shifted up to SCALE_TOP places
  localparam int PER_W = $clog2(NATURAL_PERIOD + 64'd1) + int'(SCALE_TOP);
  // Error magnitude, and twice the error one bit wider
  localparam int ERR_W = (PER_W > GOAL_W) ? PER_W : GOAL_W;
  localparam int MAG_W = ERR_W + 1;

  localparam logic [PER_W-1:0] NAT_PERIOD = PER_W'(NATURAL_PERIOD);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_INIT,
    ST_NERR,
    ST_CMP,
    ST_FIN
  } pps_state_t;

endpackage

[hw/rtl/pps_if.sv]
// Valid/ready channel interfaces for the request and response words.
interface pps_req_if
  import pps_pkg::*;
  (input logic clk);
  logic              valid;
  logic              ready;
  logic [GOAL_W-1:0] clock_hz;
  logic [GOAL_W-1:0] wanted_hz;

  modport source (output valid, output clock_hz, output wanted_hz, input ready);
  modport sink   (input valid, input clock_hz, input wanted_hz, output ready);
endinterface

interface pps_rsp_if
  import pps_pkg::*;
  (input logic clk);
  logic               valid;
  logic               ready;
  logic [SCALE_W-1:0] scale;
  logic               bad_target;

  modport source (output valid, output scale, output bad_target, input ready);
  modport sink   (input valid, input scale, input bad_target, output ready);
endinterface

[hw/rtl/pps_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module pps_div
  import pps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [GOAL_W-1:0] dividend,
  input  logic [GOAL_W-1:0] divisor,
  output logic [GOAL_W-1:0] quotient,
  output logic              done
);

  localparam int CNT_W = $clog2(GOAL_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GOAL_W - 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [GOAL_W-1:0] rem;
  logic [GOAL_W-1:0] quo;
  logic [GOAL_W-1:0] dvs;

  logic [GOAL_W:0]   rem_sh;
  logic [GOAL_W:0]   rem_diff;
  logic              q_bit;
  logic [GOAL_W-1:0] rem_step;

  always_comb begin
    rem_sh   = {rem, quo[GOAL_W-1]};
    rem_diff = rem_sh - {1'b0, dvs};
    q_bit    = (rem_sh >= {1'b0, dvs});
    rem_step = q_bit ? rem_diff[GOAL_W-1:0] : rem_sh[GOAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_step;
      quo <= {quo[GOAL_W-2:0], q_bit};
    end
  end

  assign quotient = quo;

endmodule

[hw/rtl/pwm_prescale_select.sv]
// Top level: PWM prescale exponent selection from clock and target frequency.
//
// Takes one request word (clock_hz, wanted_hz) and returns one response word
// (scale, bad_target). The wanted period is clock_hz / wanted_hz, truncated,
// from a serial divider. The search then starts at the natural counter period
// (65536 ticks) at scale 0 and doubles the period while the error of the
// doubled period stays strictly below twice the current error, stopping at
// scale 15. Each search step runs on one shared absolute-difference unit (new
// error, then compare and update). A zero wanted_hz skips the division and
// answers with scale 0 and bad_target set. One request is in work at a time:
// req.ready is high only while the sequencer is idle. The response sits in an
// output register, so the next request is taken while the previous word
// waits.
module pwm_prescale_select
  import pps_pkg::*;
(
  input logic     clk,
  input logic     rst,
  pps_req_if.sink   req,
  pps_rsp_if.source rsp
);

  pps_state_t state, state_next;

  // Divider hookup
  logic              div_start;
  logic              div_done;
  logic [GOAL_W-1:0] div_quot;

  // Search datapath
  logic [PER_W-1:0]   period;
  logic [ERR_W-1:0]   err;
  logic [ERR_W-1:0]   nerr;
  logic [SCALE_W-1:0] scale_cnt;
  logic               bad;

  // Shared abs-difference unit
  logic [PER_W-1:0] cand;
  logic [ERR_W-1:0] goal_ext;
  logic [ERR_W-1:0] gap;
  logic             beats;   // doubled period's error is strictly below twice the current error

  // Response register
  logic               res_valid;
  logic [SCALE_W-1:0] res_scale;
  logic               res_bad;
  logic               res_load;

  pps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req.clock_hz),
    .divisor  (req.wanted_hz),
    .quotient (div_quot),
    .done     (div_done)
  );

  function automatic logic [ERR_W-1:0] abs_gap(input logic [ERR_W-1:0] a,
                                               input logic [ERR_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // One subtractor pair serves both the initial and the per-step error
  always_comb begin
    cand     = (state == ST_NERR) ? (period << 1) : period;
    goal_ext = ERR_W'(div_quot);
    gap      = abs_gap(goal_ext, ERR_W'(cand));
    beats    = ({1'b0, nerr} < {err, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req.wanted_hz == '0) begin
            state_next = ST_FIN;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        state_next = ST_NERR;
      end
      ST_NERR: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (!beats || scale_cnt == SCALE_TOP - 1'b1) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_NERR;
        end
      end
      ST_FIN: begin
        if (!res_valid || rsp.ready) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Search registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      bad       <= (req.wanted_hz == '0);
      scale_cnt <= '0;
      period    <= NAT_PERIOD;
    end
    if (state == ST_INIT) begin
      err <= gap;
    end
    if (state == ST_NERR) begin
      nerr <= gap;
    end
    if (state == ST_CMP && beats) begin
      period    <= period << 1;
      err       <= nerr;
      scale_cnt <= scale_cnt + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_scale <= scale_cnt;
      res_bad   <= bad;
    end
  end

  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = res_valid;
  assign rsp.scale      = res_scale;
  assign rsp.bad_target = res_bad;

`ifndef NO_ASSERTIONS
  // A flagged target always reports scale 0
  a_bad_scale: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.bad_target |-> rsp.scale == '0)
    else $error("bad_target response with nonzero scale");

  // Divider completion only arrives while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider done outside division phase");

  // Compare never runs at the top scale
  a_scale_top: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> scale_cnt != SCALE_TOP)
    else $error("compare step at top scale");

  // Candidate period tracks the scale counter
  a_period: assert property (@(posedge clk) disable iff (rst)
    state == ST_NERR |-> period == (NAT_PERIOD << scale_cnt))
    else $error("period out of step with scale");

  // A response is loaded only into a free or draining output register
  a_res_load: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !res_valid || rsp.ready)
    else $error("response overwritten while pending");
`endif

endmodule
